// ===== hdl/ajb_pkg.sv =====
// shared types and codes for the join and backoff machine
package ajb_pkg;

    // phase codes
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_COLD    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_GATE    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_REQUEST = 3'd2;
    localparam logic [PHASE_W-1:0] PH_AWAIT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BACKOFF = 3'd4;
    localparam logic [PHASE_W-1:0] PH_JOINED  = 3'd5;

    // outcome codes reported with each result item
    localparam int OUTCOME_W = 4;
    localparam logic [OUTCOME_W-1:0] OC_SYNC    = 4'd0;
    localparam logic [OUTCOME_W-1:0] OC_LISTEN  = 4'd1;
    localparam logic [OUTCOME_W-1:0] OC_SENT    = 4'd2;
    localparam logic [OUTCOME_W-1:0] OC_TXERR   = 4'd3;
    localparam logic [OUTCOME_W-1:0] OC_FOREIGN = 4'd4;
    localparam logic [OUTCOME_W-1:0] OC_TIMEOUT = 4'd5;
    localparam logic [OUTCOME_W-1:0] OC_JOINED  = 4'd6;
    localparam logic [OUTCOME_W-1:0] OC_BACKOFF = 4'd7;
    localparam logic [OUTCOME_W-1:0] OC_ALREADY = 4'd8;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_ADDR_W-1:0] CFG_GATE_LEN      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLY_LEN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BACKOFF_BASE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BACKOFF_MAX   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ATTEMPT_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEVICE_ID     = 3'd5;

    // stream widths
    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 4;

    // attempt counter saturation point
    localparam logic [6:0] ATTEMPTS_SAT = 7'd127;

    typedef struct packed {
        logic [15:0] gate_len;
        logic [15:0] reply_len;
        logic [31:0] backoff_base;
        logic [31:0] backoff_max;
        logic [6:0]  attempt_limit;
        logic [63:0] device_id;
    } ajb_cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [31:0]        steps_left;
        logic [6:0]         attempts;
        logic [7:0]         seq_num;
        logic [15:0]        saved_address;
        logic [7:0]         saved_slot;
        logic [7:0]         saved_slot_total;
        logic [31:0]        saved_slot_length;
    } ajb_state_t;

    typedef struct packed {
        logic        sync_heard;
        logic        tx_ok;
        logic        frame_heard;
        logic        frame_valid;
        logic [63:0] target_id;
        logic [15:0] assigned_address;
        logic [7:0]  assigned_slot;
        logic [7:0]  assigned_slot_total;
        logic [31:0] assigned_slot_length;
        logic [15:0] random_value;
    } ajb_item_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [7:0]           request_seq;
        logic                 joined;
        logic [15:0]          held_address;
        logic [7:0]           held_slot;
        logic [7:0]           held_slot_total;
        logic [31:0]          held_slot_length;
        logic [6:0]           attempt_count;
    } ajb_result_t;

endpackage

// ===== hdl/ajb_step.sv =====
// next-state and result logic for one step of the join machine
module ajb_step (
    input  ajb_pkg::ajb_cfg_t    cfg,
    input  ajb_pkg::ajb_state_t  state_cur,
    input  ajb_pkg::ajb_item_t   item,
    output ajb_pkg::ajb_state_t  state_next,
    output ajb_pkg::ajb_result_t result
);
    import ajb_pkg::*;

    ajb_state_t          st;
    ajb_state_t          nxt;
    logic [PHASE_W-1:0]  cold_phase;
    logic [31:0]         cold_steps;
    logic [63:0]         shifted;
    logic [31:0]         window;
    logic [32:0]         window_plus;
    logic [48:0]         product;
    logic [31:0]         delay;
    logic [6:0]          att_inc;
    logic                restart;
    logic [31:0]         steps_dec;
    logic                dec_zero;
    logic                id_match;

    // cold start target
    assign cold_phase = (cfg.gate_len != 16'd0) ? PH_GATE : PH_REQUEST;
    assign cold_steps = {16'd0, cfg.gate_len};

    // state as seen by this step, with a pending cold start applied first
    always_comb begin
        st = state_cur;
        if (state_cur.phase == PH_COLD) begin
            st.attempts   = 7'd0;
            st.phase      = cold_phase;
            st.steps_left = cold_steps;
        end
    end

    // truncated exponential window, clamped to backoff_max
    assign shifted = {32'd0, cfg.backoff_base} << st.attempts[4:0];
    always_comb begin
        if (cfg.backoff_base == 32'd0) begin
            window = 32'd0;
        end else if (st.attempts >= 7'd32) begin
            window = cfg.backoff_max;
        end else if (shifted > {32'd0, cfg.backoff_max}) begin
            window = cfg.backoff_max;
        end else begin
            window = shifted[31:0];
        end
    end

    // random draw scaled into 0..window
    assign window_plus = {1'b0, window} + 33'd1;
    assign product     = 49'(item.random_value) * 49'(window_plus);
    assign delay       = product[47:16];

    // attempt bookkeeping on a failed attempt
    assign att_inc = (st.attempts < ATTEMPTS_SAT) ? st.attempts + 7'd1 : st.attempts;
    assign restart = (cfg.attempt_limit != 7'd0) && (att_inc >= cfg.attempt_limit);

    // countdown shared by gate, await and backoff
    assign steps_dec = st.steps_left - {31'd0, (st.steps_left != 32'd0)};
    assign dec_zero  = (steps_dec == 32'd0);

    assign id_match = item.frame_heard && item.frame_valid && (item.target_id == cfg.device_id);

    // phase transitions
    always_comb begin
        nxt                = st;
        result.outcome     = OC_ALREADY;
        result.request_seq = 8'd0;
        unique case (st.phase)
            PH_GATE: begin
                if (item.sync_heard) begin
                    nxt.phase      = PH_REQUEST;
                    result.outcome = OC_SYNC;
                end else begin
                    nxt.steps_left = steps_dec;
                    if (dec_zero) begin
                        nxt.phase = PH_REQUEST;
                    end
                    result.outcome = OC_LISTEN;
                end
            end
            PH_REQUEST: begin
                result.request_seq = st.seq_num;
                nxt.seq_num        = st.seq_num + 8'd1;
                if (item.tx_ok) begin
                    nxt.phase      = PH_AWAIT;
                    nxt.steps_left = {16'd0, cfg.reply_len};
                    result.outcome = OC_SENT;
                end else begin
                    if (restart) begin
                        nxt.attempts   = 7'd0;
                        nxt.phase      = cold_phase;
                        nxt.steps_left = cold_steps;
                    end else begin
                        nxt.attempts   = att_inc;
                        nxt.phase      = PH_BACKOFF;
                        nxt.steps_left = delay;
                    end
                    result.outcome = OC_TXERR;
                end
            end
            PH_AWAIT: begin
                if (id_match) begin
                    nxt.phase             = PH_JOINED;
                    nxt.saved_address     = item.assigned_address;
                    nxt.saved_slot        = item.assigned_slot;
                    nxt.saved_slot_total  = item.assigned_slot_total;
                    nxt.saved_slot_length = item.assigned_slot_length;
                    result.outcome        = OC_JOINED;
                end else begin
                    nxt.steps_left = steps_dec;
                    if (dec_zero) begin
                        if (restart) begin
                            nxt.attempts   = 7'd0;
                            nxt.phase      = cold_phase;
                            nxt.steps_left = cold_steps;
                        end else begin
                            nxt.attempts   = att_inc;
                            nxt.phase      = PH_BACKOFF;
                            nxt.steps_left = delay;
                        end
                    end
                    result.outcome = item.frame_heard ? OC_FOREIGN : OC_TIMEOUT;
                end
            end
            PH_BACKOFF: begin
                nxt.steps_left = steps_dec;
                if (dec_zero) begin
                    nxt.phase = PH_REQUEST;
                end
                result.outcome = OC_BACKOFF;
            end
            default: begin
                result.outcome = OC_ALREADY;
            end
        endcase

        // held assignment shows only while joined
        result.joined           = (nxt.phase == PH_JOINED);
        result.held_address     = result.joined ? nxt.saved_address : 16'd0;
        result.held_slot        = result.joined ? nxt.saved_slot : 8'd0;
        result.held_slot_total  = result.joined ? nxt.saved_slot_total : 8'd0;
        result.held_slot_length = result.joined ? nxt.saved_slot_length : 32'd0;
        result.attempt_count    = nxt.attempts;
    end

    assign state_next = nxt;

endmodule

// ===== hdl/aloha_join_backoff_fsm.sv =====
// top level of the slotted-aloha join machine with truncated exponential backoff
//
// Each input item is one step of the join machine and carries the outcome of the
// radio action of the current phase. Exactly one result item comes out per input
// item, in order: the step outcome, the request sequence number, the join status,
// the captured assignment and the attempt count.
// The input item is first held in an input register; the step logic then runs
// between that register and the result register, and the machine state updates
// as the item moves into the result register and becomes a valid result item.
// One item per cycle is sustained while the receiver keeps taking results.
// The result register frees in the same cycle it is taken, so a stalled receiver
// only holds the pipe: at most two items are held and none is lost.
// Configuration is written through cfg_wr_en / cfg_addr / cfg_wdata; unknown
// indexes are ignored. Only write while the block is idle; it is not enforced.
// Reset (aresetn low, synchronous) loads the register defaults, empties both
// stages and leaves the machine with a cold start pending for its first step.
module aloha_join_backoff_fsm (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ajb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ajb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // target_id, assigned_address, assigned_slot, assigned_slot_total,
    // assigned_slot_length, random_value
    input  logic [ajb_pkg::S_TDATA_W-1:0]       s_tdata,
    // sync_heard, tx_ok, frame_heard, frame_valid
    input  logic [ajb_pkg::S_TUSER_W-1:0]       s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // request_seq, joined, held_address, held_slot, held_slot_total,
    // held_slot_length, attempt_count
    output logic [ajb_pkg::M_TDATA_W-1:0]       m_tdata,
    // outcome
    output logic [ajb_pkg::M_TUSER_W-1:0]       m_tuser
);
    import ajb_pkg::*;

    ajb_cfg_t    cfg_reg;
    ajb_state_t  state_reg;
    ajb_state_t  state_next;
    ajb_item_t   item_reg;
    logic        item_valid_reg;
    ajb_result_t result_next;
    ajb_result_t result_reg;
    logic        result_valid_reg;
    logic        advance;
    logic        s_accept;

    // pipeline handshake
    assign advance  = item_valid_reg && (!result_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gate_len      <= 16'd0;
            cfg_reg.reply_len     <= 16'd1;
            cfg_reg.backoff_base  <= 32'd1;
            cfg_reg.backoff_max   <= 32'd64;
            cfg_reg.attempt_limit <= 7'd0;
            cfg_reg.device_id     <= 64'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_GATE_LEN:      cfg_reg.gate_len      <= cfg_wdata[15:0];
                CFG_REPLY_LEN:     cfg_reg.reply_len     <= cfg_wdata[15:0];
                CFG_BACKOFF_BASE:  cfg_reg.backoff_base  <= cfg_wdata[31:0];
                CFG_BACKOFF_MAX:   cfg_reg.backoff_max   <= cfg_wdata[31:0];
                CFG_ATTEMPT_LIMIT: cfg_reg.attempt_limit <= cfg_wdata[6:0];
                CFG_DEVICE_ID:     cfg_reg.device_id     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_accept) begin
            item_valid_reg <= 1'b1;
        end else if (advance) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.sync_heard           <= s_tuser[0];
            item_reg.tx_ok                <= s_tuser[1];
            item_reg.frame_heard          <= s_tuser[2];
            item_reg.frame_valid          <= s_tuser[3];
            item_reg.target_id            <= s_tdata[63:0];
            item_reg.assigned_address     <= s_tdata[79:64];
            item_reg.assigned_slot        <= s_tdata[87:80];
            item_reg.assigned_slot_total  <= s_tdata[95:88];
            item_reg.assigned_slot_length <= s_tdata[127:96];
            item_reg.random_value         <= s_tdata[143:128];
        end
    end

    // step logic
    ajb_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // machine state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase             <= PH_COLD;
            state_reg.steps_left        <= 32'd0;
            state_reg.attempts          <= 7'd0;
            state_reg.seq_num           <= 8'd0;
            state_reg.saved_address     <= 16'd0;
            state_reg.saved_slot        <= 8'd0;
            state_reg.saved_slot_total  <= 8'd0;
            state_reg.saved_slot_length <= 32'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (m_tready) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // result packing
    assign m_tvalid = result_valid_reg;
    assign m_tuser  = result_reg.outcome;
    assign m_tdata  = {result_reg.attempt_count,
                       result_reg.held_slot_length,
                       result_reg.held_slot_total,
                       result_reg.held_slot,
                       result_reg.held_address,
                       result_reg.joined,
                       result_reg.request_seq};

endmodule

// ===== tb/tb_aloha_join_backoff_fsm.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the slotted-aloha join and backoff machine
module tb_aloha_join_backoff_fsm;
    import ajb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // target_id, assigned_address, assigned_slot, assigned_slot_total,
    // assigned_slot_length, random_value
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // sync_heard, tx_ok, frame_heard, frame_valid
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // request_seq, joined, held_address, held_slot, held_slot_total,
    // held_slot_length, attempt_count
    logic [M_TDATA_W-1:0]  m_tdata;
    // outcome
    logic [M_TUSER_W-1:0]  m_tuser;

    // predicted registers and machine state
    ajb_cfg_t    regs;
    ajb_state_t  mach;
    ajb_result_t pending_results[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  ready_hold = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;

    aloha_join_backoff_fsm i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register defaults and a pending cold start
    function automatic void reset_model();
        regs.gate_len      = 16'd0;
        regs.reply_len     = 16'd1;
        regs.backoff_base  = 32'd1;
        regs.backoff_max   = 32'd64;
        regs.attempt_limit = 7'd0;
        regs.device_id     = 64'd0;
        mach = '0;
        mach.phase = PH_COLD;
    endfunction

    // backoff window for an attempt count, a shift past 32 bits gives the clamp
    function automatic logic [31:0] backoff_window(logic [6:0] att);
        logic [63:0] w;
        if (regs.backoff_base == 32'd0) return 32'd0;
        if (att >= 7'd32) return regs.backoff_max;
        w = {32'd0, regs.backoff_base} << att;
        if (w > {32'd0, regs.backoff_max}) w = {32'd0, regs.backoff_max};
        return w[31:0];
    endfunction

    function automatic void cold_restart();
        mach.attempts = 7'd0;
        if (regs.gate_len != 16'd0) begin
            mach.phase = PH_GATE;
            mach.steps_left = {16'd0, regs.gate_len};
        end else begin
            mach.phase = PH_REQUEST;
            mach.steps_left = 32'd0;
        end
    endfunction

    // count a failed attempt and pick the delay, or restart at the cap
    function automatic void start_retry_wait(logic [15:0] rnd);
        logic [31:0] win;
        logic [63:0] prod;
        win = backoff_window(mach.attempts);
        prod = {48'd0, rnd} * ({32'd0, win} + 64'd1);
        if (mach.attempts != ATTEMPTS_SAT) mach.attempts = mach.attempts + 7'd1;
        if (regs.attempt_limit != 7'd0 && mach.attempts >= regs.attempt_limit) begin
            cold_restart();
        end else begin
            mach.phase = PH_BACKOFF;
            mach.steps_left = prod[47:16];
        end
    endfunction

    // one step of the join machine: advances the state, returns the result item
    function automatic ajb_result_t step_join_machine(ajb_item_t it);
        ajb_result_t r;
        r = '0;
        if (mach.phase == PH_COLD) cold_restart();
        case (mach.phase)
            PH_GATE: begin
                if (it.sync_heard) begin
                    mach.phase = PH_REQUEST;
                    r.outcome = OC_SYNC;
                end else begin
                    if (mach.steps_left != 32'd0) mach.steps_left = mach.steps_left - 32'd1;
                    if (mach.steps_left == 32'd0) mach.phase = PH_REQUEST;
                    r.outcome = OC_LISTEN;
                end
            end
            PH_REQUEST: begin
                r.request_seq = mach.seq_num;
                mach.seq_num = mach.seq_num + 8'd1;
                if (it.tx_ok) begin
                    mach.phase = PH_AWAIT;
                    mach.steps_left = {16'd0, regs.reply_len};
                    r.outcome = OC_SENT;
                end else begin
                    start_retry_wait(it.random_value);
                    r.outcome = OC_TXERR;
                end
            end
            PH_AWAIT: begin
                if (it.frame_heard && it.frame_valid && it.target_id == regs.device_id) begin
                    mach.phase = PH_JOINED;
                    mach.saved_address = it.assigned_address;
                    mach.saved_slot = it.assigned_slot;
                    mach.saved_slot_total = it.assigned_slot_total;
                    mach.saved_slot_length = it.assigned_slot_length;
                    r.outcome = OC_JOINED;
                end else begin
                    if (mach.steps_left != 32'd0) mach.steps_left = mach.steps_left - 32'd1;
                    if (mach.steps_left == 32'd0) start_retry_wait(it.random_value);
                    r.outcome = it.frame_heard ? OC_FOREIGN : OC_TIMEOUT;
                end
            end
            PH_BACKOFF: begin
                if (mach.steps_left != 32'd0) mach.steps_left = mach.steps_left - 32'd1;
                if (mach.steps_left == 32'd0) mach.phase = PH_REQUEST;
                r.outcome = OC_BACKOFF;
            end
            default: r.outcome = OC_ALREADY;
        endcase
        if (mach.phase == PH_JOINED) begin
            r.joined = 1'b1;
            r.held_address = mach.saved_address;
            r.held_slot = mach.saved_slot;
            r.held_slot_total = mach.saved_slot_total;
            r.held_slot_length = mach.saved_slot_length;
        end
        r.attempt_count = mach.attempts;
        return r;
    endfunction

    // random step item shaped to the predicted phase; keeps backoff delays short
    // and never lets a qualifying assignment reach the await phase
    function automatic ajb_item_t make_step(int fail_pct);
        ajb_item_t   it;
        logic [2:0]  ph;
        logic [31:0] left;
        logic [6:0]  att;
        logic [31:0] win;
        logic [63:0] rnd_cap;
        it.sync_heard = 1'($urandom);
        it.tx_ok = 1'($urandom);
        it.frame_heard = 1'($urandom);
        it.frame_valid = 1'($urandom);
        it.target_id = {$urandom, $urandom};
        it.assigned_address = 16'($urandom);
        it.assigned_slot = 8'($urandom);
        it.assigned_slot_total = 8'($urandom);
        it.assigned_slot_length = $urandom;
        it.random_value = 16'($urandom);
        ph = mach.phase;
        left = mach.steps_left;
        att = mach.attempts;
        if (ph == PH_COLD) begin
            ph = (regs.gate_len != 16'd0) ? PH_GATE : PH_REQUEST;
            left = {16'd0, regs.gate_len};
            att = 7'd0;
        end
        case (ph)
            PH_GATE: begin
                if (left > 32'd30) it.sync_heard = ($urandom_range(0, 3) != 0);
                else it.sync_heard = ($urandom_range(0, 3) == 0);
            end
            PH_REQUEST: it.tx_ok = ($urandom_range(0, 99) >= fail_pct);
            PH_AWAIT: begin
                it.frame_heard = 1'($urandom_range(0, 1));
                it.frame_valid = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 3))
                    0: it.target_id = regs.device_id ^ (64'd1 << $urandom_range(0, 63));
                    1: it.target_id = regs.device_id;
                    default: ;
                endcase
                if (it.frame_heard && it.frame_valid && it.target_id == regs.device_id)
                    it.frame_valid = 1'b0;
            end
            default: ;
        endcase
        // a matching assignment outside await must be ignored
        if (ph != PH_AWAIT && $urandom_range(0, 7) == 0) begin
            it.frame_heard = 1'b1;
            it.frame_valid = 1'b1;
            it.target_id = regs.device_id;
        end
        if (ph == PH_REQUEST || ph == PH_AWAIT) begin
            win = backoff_window(att);
            if (win > 32'd24) begin
                rnd_cap = (64'd25 << 16) / ({32'd0, win} + 64'd1);
                it.random_value = 16'($urandom_range(0, int'(rnd_cap)));
            end
        end
        return it;
    endfunction

    // step item with chosen flags, the assignment fields random
    function automatic ajb_item_t pick_step(int sync, int tx, int heard, int valid,
                                            logic [63:0] target, logic [15:0] rnd);
        ajb_item_t it;
        it.sync_heard = 1'(sync);
        it.tx_ok = 1'(tx);
        it.frame_heard = 1'(heard);
        it.frame_valid = 1'(valid);
        it.target_id = target;
        it.assigned_address = 16'($urandom);
        it.assigned_slot = 8'($urandom);
        it.assigned_slot_total = 8'($urandom);
        it.assigned_slot_length = $urandom;
        it.random_value = rnd;
        return it;
    endfunction

    // idle gap length, mostly short
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // send one step item and record its expected result on acceptance
    task automatic send_step(input ajb_item_t it);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.random_value, it.assigned_slot_length, it.assigned_slot_total,
                    it.assigned_slot, it.assigned_address, it.target_id};
        s_tuser <= {it.frame_valid, it.frame_heard, it.tx_ok, it.sync_heard};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(step_join_machine(it));
    endtask

    // hold off the sender until every expected result is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write all six registers back to back, only while idle
    task automatic load_regs(input logic [15:0] gate, input logic [15:0] await_len,
                             input logic [31:0] base, input logic [31:0] clamp,
                             input logic [6:0] max_att, input logic [63:0] dev);
        logic [CFG_ADDR_W-1:0] idx [6];
        logic [63:0]           val [6];
        idx = '{CFG_GATE_LEN, CFG_REPLY_LEN, CFG_BACKOFF_BASE,
                CFG_BACKOFF_MAX, CFG_ATTEMPT_LIMIT, CFG_DEVICE_ID};
        val = '{64'(gate), 64'(await_len), 64'(base), 64'(clamp), 64'(max_att), dev};
        foreach (idx[k]) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= idx[k];
            cfg_wdata <= val[k];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        regs.gate_len = gate;
        regs.reply_len = await_len;
        regs.backoff_base = base;
        regs.backoff_max = clamp;
        regs.attempt_limit = max_att;
        regs.device_id = dev;
    endtask

    task automatic run_random(input int count, input int fail_pct);
        repeat (count) send_step(make_step(fail_pct));
    endtask

    // cold start, gate expiry, zero windows, request failure, cap restart
    task automatic test_directed_steps();
        logic [63:0] ones;
        ones = '1;
        load_regs(16'd2, 16'd0, 32'd0, 32'hFFFF_FFFF, 7'd2, ones);
        send_step(pick_step(0, 0, 0, 0, 64'd0, 16'h0000));
        send_step(pick_step(0, 0, 0, 0, ones, 16'hFFFF));
        // request fails with a zero base
        send_step(pick_step(0, 0, 1, 1, ones, 16'hFFFF));
        send_step(pick_step(1, 1, 1, 1, ones, 16'hFFFF));
        send_step(pick_step(0, 1, 0, 0, 64'd0, 16'h0000));
        // zero await window, foreign frame hits the cap
        send_step(pick_step(0, 0, 1, 1, ones ^ 64'd1, 16'hFFFF));
        send_step(pick_step(1, 0, 0, 0, 64'd0, 16'h0000));
        send_step(pick_step(0, 1, 0, 0, 64'd0, 16'h0000));
        send_step(pick_step(0, 0, 0, 1, ones, 16'h0000));
        send_step(pick_step(0, 0, 0, 0, 64'd0, 16'hFFFF));
        wait_idle();
        // gate skipped, clamp of zero, matching target that does not qualify
        load_regs(16'd0, 16'd3, 32'hFFFF_FFFF, 32'd0, 7'd0, 64'd0);
        send_step(pick_step(0, 1, 0, 0, ones, 16'hFFFF));
        send_step(pick_step(1, 1, 1, 0, 64'd0, 16'h0000));
        send_step(pick_step(1, 1, 0, 1, 64'd0, 16'hFFFF));
        send_step(pick_step(0, 0, 1, 1, ones, 16'hFFFF));
        send_step(pick_step(0, 0, 0, 0, 64'd0, 16'h0000));
        send_step(pick_step(1, 0, 1, 1, 64'd0, 16'hFFFF));
        send_step(pick_step(0, 0, 0, 0, 64'd0, 16'h0000));
        send_step(pick_step(0, 1, 0, 0, 64'd0, 16'h0000));
        wait_idle();
    endtask

    task automatic test_gated_traffic();
        load_regs(16'd5, 16'd3, 32'd1, 32'd64, 7'd5, {$urandom, $urandom});
        run_random(100, 25);
        wait_idle();
    endtask

    task automatic test_back_to_back();
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        load_regs(16'd0, 16'd0, 32'd3, 32'd1000, 7'd0, {$urandom, $urandom});
        run_random(100, 25);
        wait_idle();
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // unlimited attempts with a shift that overflows, runs the counter to 127
    task automatic test_attempt_saturation();
        load_regs(16'd1, 16'd1, 32'h8000_0000, 32'hFFFF_FFFF, 7'd0, 64'd0);
        run_random(280, 95);
        wait_idle();
    endtask

    task automatic test_attempt_cap();
        load_regs(16'd40, 16'd6, 32'h0000_FFFF, 32'h0001_2345, 7'd127, {$urandom, $urandom});
        run_random(100, 30);
        wait_idle();
    endtask

    task automatic test_restart_each_failure();
        load_regs(16'd3, 16'd2, 32'd2, 32'd7, 7'd1, {$urandom, $urandom});
        run_random(100, 40);
        wait_idle();
    endtask

    task automatic test_mixed_settings();
        repeat (3) begin
            tx_burst = 1'($urandom_range(0, 1));
            rx_burst = 1'($urandom_range(0, 1));
            load_regs(16'($urandom_range(0, 8)), 16'($urandom_range(0, 5)), $urandom,
                      $urandom, 7'($urandom_range(0, 12)), {$urandom, $urandom});
            run_random(30, 30);
            wait_idle();
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // long gate and await windows, capture of an assignment, then already joined
    task automatic test_join_capture();
        ajb_item_t it;
        int guard;
        load_regs(16'hFFFF, 16'hFFFF, 32'd1, 32'd64, 7'd127, {$urandom, $urandom});
        guard = 0;
        while (!(mach.phase == PH_AWAIT && mach.steps_left > 32'd4) && guard < 400) begin
            it = make_step(0);
            it.sync_heard = 1'b1;
            it.tx_ok = 1'b1;
            send_step(it);
            guard++;
        end
        send_step(pick_step(0, 0, 1, 1, regs.device_id ^ 64'h8000_0000_0000_0000, 16'hFFFF));
        send_step(pick_step(0, 0, 0, 0, regs.device_id, 16'h0000));
        it = pick_step(0, 0, 1, 1, regs.device_id, 16'hFFFF);
        it.assigned_address = '1;
        it.assigned_slot = '1;
        it.assigned_slot_total = '1;
        it.assigned_slot_length = '1;
        send_step(it);
        repeat (4) begin
            it = make_step(0);
            it.frame_heard = 1'b1;
            it.frame_valid = 1'b1;
            it.target_id = regs.device_id;
            it.assigned_address = '0;
            it.assigned_slot = '0;
            it.assigned_slot_total = '0;
            it.assigned_slot_length = '0;
            send_step(it);
        end
        wait_idle();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // result side: compare each accepted item, random receiver stalls
    always @(posedge aclk) begin : result_side
        ajb_result_t want;
        int r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result item with none expected, outcome %0h", m_tuser);
            end else begin
                want = pending_results.pop_front();
                check_field("outcome", 64'(want.outcome), 64'(m_tuser));
                check_field("request_seq", 64'(want.request_seq), 64'(m_tdata[7:0]));
                check_field("joined", 64'(want.joined), 64'(m_tdata[8]));
                check_field("held_address", 64'(want.held_address), 64'(m_tdata[24:9]));
                check_field("held_slot", 64'(want.held_slot), 64'(m_tdata[32:25]));
                check_field("held_slot_total", 64'(want.held_slot_total),
                            64'(m_tdata[40:33]));
                check_field("held_slot_length", 64'(want.held_slot_length),
                            64'(m_tdata[72:41]));
                check_field("attempt_count", 64'(want.attempt_count), 64'(m_tdata[79:73]));
            end
        end
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_burst) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                m_tready <= 1'b1;
            end else if (r < 96) begin
                m_tready <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_aloha_join_backoff_fsm NOT OK");
        $finish;
    end

    initial begin
        reset_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_steps();
        test_gated_traffic();
        test_back_to_back();
        test_attempt_saturation();
        test_attempt_cap();
        test_restart_each_failure();
        test_mixed_settings();
        test_join_capture();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_aloha_join_backoff_fsm OK");
        end else begin
            $display("tb_aloha_join_backoff_fsm NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ajb_pkg.sv
hdl/ajb_step.sv
hdl/aloha_join_backoff_fsm.sv
tb/tb_aloha_join_backoff_fsm.sv
